// ===== rtl/arrdq_pkg.sv =====
// ----------------------------------------------------------------------------
// Array deque package
// Action and status codes, datapath commands and the status bundle shared by
// the controller and the datapath of the array deque.
// ----------------------------------------------------------------------------
package arrdq_pkg;

    localparam int WORD_W = 32;

    typedef enum logic [1:0] {
        ACT_APPEND      = 2'd0,
        ACT_PREPEND     = 2'd1,
        ACT_REMOVE_HEAD = 2'd2,
        ACT_REMOVE_TAIL = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_REMOVED   = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_UNDERFLOW = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_CAPTURE,
        CMD_FIRST,
        CMD_OVERFLOW,
        CMD_APPEND,
        CMD_SHIFT_START,
        CMD_SHIFT,
        CMD_PUT,
        CMD_UNDERFLOW,
        CMD_REMOVE_HEAD,
        CMD_REMOVE_TAIL,
        CMD_REMOVE_LAST,
        CMD_LOAD_WORD,
        CMD_PUBLISH
    } t_cmd;

    typedef struct packed {
        t_action action;
        logic    is_empty;
        logic    tail_last;
        logic    single;
        logic    slot_at_head;
        logic    out_free;
    } t_dp_status;

endpackage

// ===== rtl/arrdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Array deque controller
// Sequences each beat through decode, the prepend shift loop, the store read
// and the hand-off to the output register.
// ----------------------------------------------------------------------------
module arrdq_ctrl import arrdq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_status,
    output logic       o_in_stall,
    output t_cmd       o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EXEC  = 6'b000010,
        S_SHIFT = 6'b000100,
        S_PUT   = 6'b001000,
        S_FETCH = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   is_insert;

    assign is_insert  = (i_status.action == ACT_APPEND) ||
                        (i_status.action == ACT_PREPEND);
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = CMD_CAPTURE;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (is_insert) begin
                    priority if (i_status.is_empty) begin
                        o_cmd   = CMD_FIRST;
                        n_state = S_DONE;
                    end else if (i_status.tail_last) begin
                        o_cmd   = CMD_OVERFLOW;
                        n_state = S_DONE;
                    end else if (i_status.action == ACT_APPEND) begin
                        o_cmd   = CMD_APPEND;
                        n_state = S_DONE;
                    end else begin
                        o_cmd   = CMD_SHIFT_START;
                        n_state = S_SHIFT;
                    end
                end else begin
                    priority if (i_status.is_empty) begin
                        o_cmd   = CMD_UNDERFLOW;
                        n_state = S_DONE;
                    end else if (i_status.single) begin
                        o_cmd   = CMD_REMOVE_LAST;
                        n_state = S_FETCH;
                    end else if (i_status.action == ACT_REMOVE_HEAD) begin
                        o_cmd   = CMD_REMOVE_HEAD;
                        n_state = S_FETCH;
                    end else begin
                        o_cmd   = CMD_REMOVE_TAIL;
                        n_state = S_FETCH;
                    end
                end
            end
            S_SHIFT: begin
                o_cmd = CMD_SHIFT;
                if (i_status.slot_at_head) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                o_cmd   = CMD_PUT;
                n_state = S_DONE;
            end
            S_FETCH: begin
                o_cmd   = CMD_LOAD_WORD;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd   = CMD_PUBLISH;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/arrdq_dp.sv =====
// ----------------------------------------------------------------------------
// Array deque datapath
// Word store, head and tail indices, empty flag, shift pointer, the result
// being built and the output register.
// ----------------------------------------------------------------------------
module arrdq_dp import arrdq_pkg::*; #(
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    input  logic [1:0]               i_action,
    input  logic signed [WORD_W-1:0] i_value,
    input  logic                     i_out_stall,
    output t_dp_status               o_status_bus,
    output logic                     o_out_valid,
    output logic [1:0]               o_status,
    output logic signed [WORD_W-1:0] o_removed_value
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    logic [WORD_W-1:0] mem [DEPTH];

    logic [AW-1:0]            r_head;
    logic [AW-1:0]            r_tail;
    logic                     r_empty;
    logic [AW-1:0]            r_slot;
    t_action                  r_action;
    logic signed [WORD_W-1:0] r_value;
    logic [WORD_W-1:0]        r_rd_data;
    t_status                  r_res_status;
    logic [WORD_W-1:0]        r_res_word;
    logic                     r_out_valid;
    logic [1:0]               r_out_status;
    logic [WORD_W-1:0]        r_out_word;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic [AW-1:0]     rd_addr;

    assign o_status_bus.action       = r_action;
    assign o_status_bus.is_empty     = r_empty;
    assign o_status_bus.tail_last    = (r_tail == LAST_SLOT);
    assign o_status_bus.single       = (r_head == r_tail);
    assign o_status_bus.slot_at_head = (r_slot == r_head);
    assign o_status_bus.out_free     = !r_out_valid || !i_out_stall;

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_removed_value = r_out_word;

    // Store port control. During the shift the word read last cycle goes one
    // slot up while the slot below it is read.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_tail + AW'(1);
        wr_data = r_value;
        rd_addr = r_head;
        unique case (i_cmd)
            CMD_FIRST: begin
                wr_en   = 1'b1;
                wr_addr = '0;
            end
            CMD_APPEND: begin
                wr_en = 1'b1;
            end
            CMD_SHIFT_START: begin
                rd_addr = r_tail;
            end
            CMD_SHIFT: begin
                wr_en   = 1'b1;
                wr_addr = r_slot + AW'(1);
                wr_data = r_rd_data;
                rd_addr = r_slot - AW'(1);
            end
            CMD_PUT: begin
                wr_en   = 1'b1;
                wr_addr = r_head;
            end
            CMD_REMOVE_TAIL: begin
                rd_addr = r_tail;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_empty     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            unique case (i_cmd)
                CMD_FIRST: begin
                    r_head  <= '0;
                    r_tail  <= '0;
                    r_empty <= 1'b0;
                end
                CMD_APPEND, CMD_PUT: begin
                    r_tail <= r_tail + AW'(1);
                end
                CMD_REMOVE_HEAD: begin
                    r_head <= r_head + AW'(1);
                end
                CMD_REMOVE_TAIL: begin
                    r_tail <= r_tail - AW'(1);
                end
                CMD_REMOVE_LAST: begin
                    r_head  <= '0;
                    r_tail  <= '0;
                    r_empty <= 1'b1;
                end
                default: begin
                end
            endcase
            if (i_cmd == CMD_PUBLISH) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            CMD_CAPTURE: begin
                r_action <= t_action'(i_action);
                r_value  <= i_value;
            end
            CMD_FIRST, CMD_APPEND, CMD_PUT: begin
                r_res_status <= ST_INSERTED;
                r_res_word   <= '0;
            end
            CMD_OVERFLOW: begin
                r_res_status <= ST_OVERFLOW;
                r_res_word   <= '0;
            end
            CMD_UNDERFLOW: begin
                r_res_status <= ST_UNDERFLOW;
                r_res_word   <= '0;
            end
            CMD_REMOVE_HEAD, CMD_REMOVE_TAIL, CMD_REMOVE_LAST: begin
                r_res_status <= ST_REMOVED;
            end
            CMD_LOAD_WORD: begin
                r_res_word <= r_rd_data;
            end
            CMD_SHIFT_START: begin
                r_slot <= r_tail;
            end
            CMD_SHIFT: begin
                r_slot <= r_slot - AW'(1);
            end
            CMD_PUBLISH: begin
                r_out_status <= r_res_status;
                r_out_word   <= r_res_word;
            end
            default: begin
            end
        endcase
    end

    a_empty_indices: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_empty |-> (r_head == '0) && (r_tail == '0))
        else $error("empty store with nonzero head or tail index");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_empty |-> (r_head <= r_tail))
        else $error("head index passed tail index");

    a_zero_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_REMOVED)) |-> (o_removed_value == '0))
        else $error("nonzero word on a beat that removed nothing");

    a_shift_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == CMD_SHIFT) |-> (r_slot >= r_head) && (r_slot < LAST_SLOT))
        else $error("shift pointer outside the held range");

endmodule

// ===== rtl/array_double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// Array double-ended queue
// Deque on a linear store of DEPTH words with append, prepend and removal
// at either end; one status beat per input beat.
// ----------------------------------------------------------------------------
// Inserts without shifting, overflow and underflow pass from decode straight
// to the result; removals also pass through a registered store read.
// Prepend onto held words shifts each one slot up: the shift moves one word per
// cycle through the single-write store port.
// One beat is in flight at a time; a result may wait in the output register.
// Synchronous active-low reset empties the deque; store contents are kept.
module array_double_ended_queue import arrdq_pkg::*; #(
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [1:0]               i_action,
    input  logic signed [WORD_W-1:0] i_value,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [1:0]               o_status,
    output logic signed [WORD_W-1:0] o_removed_value
);

    t_cmd       cmd;
    t_dp_status dp_status;

    arrdq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (dp_status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    arrdq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_action        (i_action),
        .i_value         (i_value),
        .i_out_stall     (i_out_stall),
        .o_status_bus    (dp_status),
        .o_out_valid     (o_out_valid),
        .o_status        (o_status),
        .o_removed_value (o_removed_value)
    );

endmodule
